/* rtl/core/fqd_pkg.sv */
// Shared types and constants for the FIFO with random quarter drop.
// No dependencies.
package fqd_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned ItemW = 32;
  localparam logic [31:0] LfsrTaps = 32'hD000_0001;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_DROP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [0:0] {
    REG_LIMIT = 1'd0,
    REG_SEED  = 1'd1
  } reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DEQ_RD, ST_PICK, ST_MOD, ST_MARK_RD, ST_MARK, ST_WALK_RD,
    ST_WALK, ST_OUT, ST_DROP_OUT
  } state_t;

  // One LFSR step, right-shifting Galois form.
  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
  endfunction

endpackage

/* rtl/core/fifo_with_random_quarter_drop_unit.sv */
// Top level of the FIFO with random quarter drop: store, sequencer, ports.
// Depends on fqd_pkg.
//
// Input channel s_axis_*: tdata = {item_in[31:0], action[1:0]} padded to 40 bits.
// Output channel m_axis_*: tdata = {items_held, error_code, item_out, kind},
// tlast marks the final result of an input; tuser = {is_empty, is_full}.
// An enqueue result is presented in the cycle after its input transfer; a dequeue
// result is registered in ST_DEQ_RD from the registered store read. The next
// input is taken the cycle after the result transfer.
// A drop draws ceil(count/4) positions; each draw is an LFSR step, a restoring
// reduction modulo the count, a mark read and a mark write, and is repeated when
// a position is already marked. The store is then walked, clearing the marks; a
// dropped entry waits until its result is taken. The drop closes via ST_OUT.
// One item is worked on at a time; s_axis_tready is high only while idle with no
// result waiting. A stalled receiver holds the result register and the sequencer.
// Reset (rst, synchronous) empties the queue, sets the limit to 64, loads the
// LFSR with 1 and clears all 64 marks in a pass with s_axis_tready low.
// Configuration is to be written through the APB port by the user only while idle;
// the block does not enforce this. A seed write reloads the LFSR (zero loads as 1).
module fifo_with_random_quarter_drop_unit
  import fqd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // action[1:0], item_in[33:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // kind[1:0], item_out[33:2], error_code[35:34],
                                      // items_held[42:36]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // is_full[0], is_empty[1]
);

  logic [CntW-1:0] queue_limit;
  logic [31:0]     lfsr_seed;
  logic [31:0]     lfsr;
  logic [AddrW-1:0] head;
  logic [CntW-1:0] count;
  logic [CntW-1:0] total;
  logic [CntW-1:0] to_mark;
  logic [CntW-1:0] walk_i;
  logic [CntW-1:0] walk_w;
  logic [AddrW-1:0] clear_i;
  logic [38:0]     rem;
  logic [5:0]      mod_bit;
  state_t          state;
  logic [ItemW-1:0] mem [Depth];
  logic [ItemW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [ItemW-1:0] wr_data;
  logic            rd_en;
  logic            wr_en;
  logic            mark_mem [Depth];
  logic            mk_rd_data;
  logic [AddrW-1:0] mk_rd_addr;
  logic [AddrW-1:0] mk_wr_addr;
  logic            mk_wr_data;
  logic            mk_rd_en;
  logic            mk_wr_en;
  logic            cfg_wr;
  logic [CntW-1:0] eff_limit;
  logic [AddrW-1:0] pos;
  logic [38:0]     trial;
  logic [1:0]      res_kind;
  logic [ItemW-1:0] res_item;
  logic [1:0]      res_err;
  logic [CntW-1:0] res_held;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign eff_limit = (queue_limit > CntW'(Depth)) ? CntW'(Depth) : queue_limit;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEED) prdata = lfsr_seed;
    else prdata = {25'd0, queue_limit};
  end

  // Item store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Drop marks: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mk_wr_en) mark_mem[mk_wr_addr] <= mk_wr_data;
    if (mk_rd_en) mk_rd_data <= mark_mem[mk_rd_addr];
  end

  assign trial = rem - ({32'd0, total} << mod_bit);
  assign pos = rem[AddrW-1:0];

  // Memory port control for both stores.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = head;
    wr_en = 1'b0;
    wr_addr = head + AddrW'(count);
    wr_data = s_axis_tdata[33:2];
    mk_rd_en = 1'b0;
    mk_rd_addr = walk_i[AddrW-1:0];
    mk_wr_en = 1'b0;
    mk_wr_addr = walk_i[AddrW-1:0];
    mk_wr_data = 1'b0;
    if (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_ENQ
        && count < eff_limit) wr_en = 1'b1;
    if (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_DEQ)
      rd_en = 1'b1;
    if (state == ST_CLEAR) begin
      mk_wr_en = 1'b1;
      mk_wr_addr = clear_i;
    end
    if (state == ST_MARK_RD) begin
      mk_rd_en = 1'b1;
      mk_rd_addr = pos;
    end
    if (state == ST_MARK && !mk_rd_data) begin
      mk_wr_en = 1'b1;
      mk_wr_addr = pos;
      mk_wr_data = 1'b1;
    end
    if (state == ST_WALK_RD) begin
      rd_en = 1'b1;
      rd_addr = head + walk_i[AddrW-1:0];
      mk_rd_en = 1'b1;
    end
    // The walk clears each mark it has read.
    if (state == ST_WALK) begin
      mk_wr_en = 1'b1;
      if (!mk_rd_data) begin
        wr_en = 1'b1;
        wr_addr = head + walk_w[AddrW-1:0];
        wr_data = rd_data;
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  // Result helper.
  logic [CntW-1:0] held;
  assign held = res_held;
  assign m_axis_tuser = {held == '0, held >= eff_limit};
  assign m_axis_tdata = {5'd0, res_held, res_err, res_item, res_kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clear_i <= '0;
      queue_limit <= CntW'(Depth);
      lfsr_seed <= 32'd1;
      lfsr <= 32'd1;
      head <= '0;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == REG_SEED) begin
          lfsr_seed <= pwdata;
          lfsr <= (pwdata == 32'd0) ? 32'd1 : pwdata;
        end else queue_limit <= pwdata[CntW-1:0];
      end
      unique case (state)
        // Clearing pass over the marks after reset.
        ST_CLEAR: begin
          clear_i <= clear_i + 1'b1;
          if (clear_i == AddrW'(Depth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          res_item <= '0;
          m_axis_tlast <= 1'b1;
          unique case (s_axis_tdata[1:0])
            ACT_ENQ: begin
              res_kind <= KIND_STATUS;
              if (count >= eff_limit) begin
                res_err <= ERR_FULL;
                res_held <= count;
              end else begin
                res_err <= ERR_NONE;
                count <= count + 1'b1;
                res_held <= count + 1'b1;
              end
              m_axis_tvalid <= 1'b1;
            end
            ACT_DEQ: begin
              if (count == '0) begin
                res_kind <= KIND_STATUS;
                res_err <= ERR_EMPTY;
                res_held <= count;
                m_axis_tvalid <= 1'b1;
              end else begin
                res_err <= ERR_NONE;
                state <= ST_DEQ_RD;
              end
            end
            ACT_DROP: begin
              if (count == '0) begin
                res_kind <= KIND_STATUS;
                res_err <= ERR_NONE;
                res_held <= count;
                m_axis_tvalid <= 1'b1;
              end else begin
                total <= count;
                to_mark <= (count + CntW'(3)) >> 2;
                state <= ST_PICK;
              end
            end
            default: begin
              res_kind <= KIND_STATUS;
              res_err <= ERR_NONE;
              res_held <= count;
              m_axis_tvalid <= 1'b1;
            end
          endcase
        end
        ST_DEQ_RD: begin
          res_item <= rd_data;
          res_kind <= KIND_DEQ;
          res_held <= count - 1'b1;
          head <= head + 1'b1;
          count <= count - 1'b1;
          m_axis_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_PICK: begin
          if (to_mark == '0) begin
            walk_i <= '0;
            walk_w <= '0;
            state <= ST_WALK_RD;
          end else begin
            lfsr <= lfsr_step(lfsr);
            rem <= {7'd0, lfsr_step(lfsr)};
            mod_bit <= 6'd31;
            state <= ST_MOD;
          end
        end
        // Restoring reduction modulo the count, one bit per cycle.
        ST_MOD: begin
          if (!trial[38]) rem <= trial;
          if (mod_bit == '0) state <= ST_MARK_RD;
          else mod_bit <= mod_bit - 1'b1;
        end
        ST_MARK_RD: state <= ST_MARK;
        ST_MARK: begin
          if (!mk_rd_data) to_mark <= to_mark - 1'b1;
          state <= ST_PICK;
        end
        ST_WALK_RD: begin
          if (walk_i == total) state <= ST_OUT;
          else state <= ST_WALK;
        end
        ST_WALK: begin
          walk_i <= walk_i + 1'b1;
          if (mk_rd_data) begin
            count <= count - 1'b1;
            res_item <= rd_data;
            res_kind <= KIND_DROP;
            res_err <= ERR_NONE;
            res_held <= count - 1'b1;
            m_axis_tlast <= (count - 1'b1) == (total - ((total + CntW'(3)) >> 2));
            m_axis_tvalid <= 1'b1;
            state <= ST_DROP_OUT;
          end else begin
            walk_w <= walk_w + 1'b1;
            state <= ST_WALK_RD;
          end
        end
        ST_DROP_OUT: if (!m_axis_tvalid || m_axis_tready) state <= ST_WALK_RD;
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* bench/fifo_with_random_quarter_drop_unit_tb.sv */
// Self-checking bench for the FIFO with random quarter drop.
// Predicts every result from its own queue model; depends on fqd_pkg and the unit.
`timescale 1ns / 100ps

module fifo_with_random_quarter_drop_unit_tb;
  import fqd_pkg::*;

  typedef struct packed {
    action_t     act;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] item;
    logic [1:0]  err;
    logic [6:0]  held;
    logic        full;
    logic        empty;
    logic        tail;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // action[1:0], item_in[33:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // kind[1:0], item_out[33:2], error_code[35:34],
                                    // items_held[42:36]
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;        // is_full[0], is_empty[1]

  fifo_with_random_quarter_drop_unit DUT (.*);

  // Predictor state.
  logic [31:0] shadow_store [Depth];
  int unsigned shadow_head, shadow_count, shadow_limit;
  logic [31:0] shadow_lfsr;

  request_t    pending_requests[$];
  answer_t     expected_answers[$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          send_gap = 0, recv_gap = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic answer_t make_answer(logic [1:0] kind, logic [31:0] item,
                                          logic [1:0] err);
    answer_t a;
    int unsigned lim;
    lim = shadow_limit > Depth ? Depth : shadow_limit;
    a.kind = kind;
    a.item = item;
    a.err = err;
    a.held = shadow_count[6:0];
    a.full = shadow_count >= lim;
    a.empty = shadow_count == 0;
    a.tail = 1'b0;
    return a;
  endfunction

  // Works out the results of one accepted request and updates the model.
  task automatic predict_queue(request_t rq);
    answer_t     out[$];
    bit          marks [Depth];
    int unsigned lim, total, to_mark, pos, w;
    logic [31:0] v;
    lim = shadow_limit > Depth ? Depth : shadow_limit;
    if (rq.act == ACT_ENQ) begin
      if (shadow_count >= lim) out.push_back(make_answer(KIND_STATUS, 0, ERR_FULL));
      else begin
        shadow_store[(shadow_head + shadow_count) % Depth] = rq.value;
        shadow_count++;
        out.push_back(make_answer(KIND_STATUS, 0, ERR_NONE));
      end
    end else if (rq.act == ACT_DEQ) begin
      if (shadow_count == 0) out.push_back(make_answer(KIND_STATUS, 0, ERR_EMPTY));
      else begin
        v = shadow_store[shadow_head];
        shadow_head = (shadow_head + 1) % Depth;
        shadow_count--;
        out.push_back(make_answer(KIND_DEQ, v, ERR_NONE));
      end
    end else if (rq.act == ACT_DROP && shadow_count > 0) begin
      total = shadow_count;
      to_mark = (total + 3) / 4;
      foreach (marks[i]) marks[i] = 0;
      while (to_mark > 0) begin
        shadow_lfsr = shadow_lfsr[0] ? ((shadow_lfsr >> 1) ^ 32'hD000_0001)
                                     : (shadow_lfsr >> 1);
        pos = shadow_lfsr % total;
        if (!marks[pos]) begin
          marks[pos] = 1;
          to_mark--;
        end
      end
      w = 0;
      for (int i = 0; i < total; i++) begin
        v = shadow_store[(shadow_head + i) % Depth];
        if (marks[i]) begin
          shadow_count--;
          out.push_back(make_answer(KIND_DROP, v, ERR_NONE));
        end else begin
          shadow_store[(shadow_head + w) % Depth] = v;
          w++;
        end
      end
    end else begin
      out.push_back(make_answer(KIND_STATUS, 0, ERR_NONE));
    end
    out[out.size() - 1].tail = 1'b1;
    foreach (out[i]) expected_answers.push_back(out[i]);
  endtask

  // Input driver: presents queued requests with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_queue(pending_requests.pop_front());
        sent_count++;
        send_gap = rand_gap();
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_requests.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, pending_requests[0].value, pending_requests[0].act};
        end
      end
    end
  end

  // Output monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    answer_t e, got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[35:34],
                m_axis_tdata[42:36], m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count++;
        end else begin
          e = expected_answers.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        recv_gap = rand_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(reg_t idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_LIMIT) shadow_limit = data[6:0];
    else shadow_lfsr = (data == 0) ? 32'd1 : data;
  endtask

  task automatic push_request(action_t a, logic [31:0] v);
    request_t r;
    r.act = a;
    r.value = v;
    pending_requests.push_back(r);
  endtask

  // Waits until every request is sent and every result has come, then lets
  // a drop that is still walking the store settle.
  task automatic drain_all();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // A burst of random requests biased towards filling then dropping.
  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) push_request(ACT_ENQ, $urandom());
      else if (r < 75) push_request(ACT_DEQ, $urandom());
      else if (r < 97) push_request(ACT_DROP, $urandom());
      else push_request(ACT_NONE, $urandom());
    end
  endtask

  initial begin
    shadow_head = 0;
    shadow_count = 0;
    shadow_limit = 64;
    shadow_lfsr = 32'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extremes of item values, unused action.
    push_request(ACT_DEQ, 32'hFFFF_FFFF);
    push_request(ACT_DROP, 0);
    push_request(ACT_NONE, 32'hFFFF_FFFF);
    push_request(ACT_ENQ, 32'h0000_0000);
    push_request(ACT_ENQ, 32'hFFFF_FFFF);
    push_request(ACT_ENQ, 32'hA5A5_5A5A);
    push_request(ACT_ENQ, 32'h5A5A_A5A5);
    push_request(ACT_ENQ, 32'h1234_5678);
    push_request(ACT_DROP, 0);
    push_request(ACT_DEQ, 0);
    push_request(ACT_DROP, 0);
    push_request(ACT_DEQ, 0);
    push_request(ACT_DEQ, 0);
    drain_all();

    // Small limit: fill until full, then lower the limit below the count.
    apb_write(REG_LIMIT, 3);
    apb_write(REG_SEED, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) push_request(ACT_ENQ, $urandom());
    drain_all();
    apb_write(REG_LIMIT, 0);
    push_request(ACT_ENQ, 32'h1);
    push_request(ACT_DROP, 0);
    push_request(ACT_DEQ, 0);
    drain_all();

    // Largest limit with a full queue and a sixteen-item drop.
    apb_write(REG_LIMIT, 127);
    apb_write(REG_SEED, 0);
    for (int i = 0; i < 66; i++) push_request(ACT_ENQ, $urandom());
    push_request(ACT_DROP, 0);
    random_burst(60);
    drain_all();

    // Random phases with varied settings.
    apb_write(REG_LIMIT, 64);
    apb_write(REG_SEED, $urandom() | 32'h1);
    random_burst(60);
    drain_all();
    apb_write(REG_LIMIT, $urandom_range(1, 20));
    apb_write(REG_SEED, $urandom());
    random_burst(60);
    drain_all();

    while (fail_count >= 0) begin
      if (fail_count == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

endmodule
